// ----- rtl/core/jti_pkg.sv -----
// Shared types, codes and defaults for the joint trajectory interpolator.
// No dependencies; used by every module in rtl/core.
package jti_pkg;

    localparam int NUM_JOINTS_DEF    = 14;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TICK_W            = 20;
    localparam int TIME_W            = 32;
    localparam int POS_W             = 32;
    localparam logic [TICK_W-1:0] TICK_PERIOD_RESET = 20'd10000;

    typedef enum logic [2:0] {
        OP_LOAD_TARGET = 3'd0,
        OP_LOAD_START  = 3'd1,
        OP_BEGIN       = 3'd2,
        OP_TICK        = 3'd3,
        OP_RESTART     = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_READ,
        ST_MUL,
        ST_EMIT
    } state_t;

    localparam logic STATUS_POINT  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         joint_index;
        logic signed [31:0] joint_position;
        logic [31:0]        waypoint_time;
    } in_req_t;

    typedef struct packed {
        logic [3:0]         out_joint_index;
        logic signed [31:0] out_position;
        logic               last_joint;
        logic               status;
    } result_t;

    typedef struct packed {
        logic load_target;
        logic load_start;
        logic begin_seg;
        logic reject;
        logic tick;
        logic restart;
        logic prep;
        logic rd;
        logic mul;
        logic emit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic seg_active;
        logic mask_full;
        logic div_done;
        logic last_joint;
    } dp_stat_t;

endpackage

// ----- rtl/core/jti_div.sv -----
// Restoring divider, one quotient bit per cycle: q = (num << FRACTION_BITS) / span.
// Requires num < span. Depends on jti_pkg.
module jti_div #(
    parameter int FRACTION_BITS = jti_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [jti_pkg::TIME_W-1:0]    num,
    input  logic [jti_pkg::TIME_W-1:0]    span,
    output logic                          done,
    output logic [FRACTION_BITS-1:0]      quotient
);
    localparam int CW = $clog2(FRACTION_BITS + 1);
    localparam int TW = jti_pkg::TIME_W;

    logic [TW-1:0]            rem_reg, rem_next;
    logic [TW-1:0]            span_reg;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     run_reg, run_next;
    logic                     done_reg, done_next;
    logic [TW:0]              shifted;
    logic                     ge;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        ge        = shifted >= {1'b0, span_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next = num;
            quo_next = '0;
            cnt_next = CW'(FRACTION_BITS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? TW'(shifted - {1'b0, span_reg}) : TW'(shifted);
            quo_next = {quo_reg[FRACTION_BITS-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (go)
            span_reg <= span;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/jti_dp.sv -----
// Datapath: joint stores, trajectory time registers, divider and per-joint multiply.
// Depends on jti_pkg and jti_div.
module jti_dp #(
    parameter int NUM_JOINTS    = jti_pkg::NUM_JOINTS_DEF,
    parameter int FRACTION_BITS = jti_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  jti_pkg::in_req_t               req,
    input  logic                           cfg_we,
    input  logic [jti_pkg::TICK_W-1:0]     cfg_wdata,
    input  jti_pkg::ctrl_cmd_t             cmd,
    output jti_pkg::dp_stat_t              stat,
    output jti_pkg::result_t               result,
    output logic                           result_valid
);
    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int TW = jti_pkg::TIME_W;
    localparam int PW = jti_pkg::POS_W;
    localparam int FW = FRACTION_BITS + 1;
    localparam int MW = PW + 1 + FW + 1;
    localparam logic [FW-1:0] ONE  = FW'(1) << FRACTION_BITS;
    localparam logic [MW-1:0] HALF = MW'(1) << (FRACTION_BITS - 1);

    logic signed [PW-1:0] start_mem [NUM_JOINTS];
    logic signed [PW-1:0] target_mem [NUM_JOINTS];

    logic [jti_pkg::TICK_W-1:0] tick_period_reg;
    logic [NUM_JOINTS-1:0]      mask_reg;
    logic [TW-1:0]              elapsed_reg, seg_start_reg, seg_goal_reg;
    logic                       active_reg;
    logic                       full_reg;
    logic [JW-1:0]              j_reg;
    logic signed [PW-1:0]       start_rd_reg, target_rd_reg;
    logic signed [MW-1:0]       prod_reg;
    jti_pkg::result_t           result_reg, result_next;
    logic                       result_valid_reg, result_valid_next;

    logic [JW-1:0]              load_idx;
    logic                       idx_ok;
    logic [TW:0]                elapsed_sum;
    logic [TW-1:0]              elapsed_sat;
    logic [TW-1:0]              goal_new;
    logic                       div_done;
    logic [FRACTION_BITS-1:0]   div_q;
    logic [FW-1:0]              frac;
    logic signed [PW:0]         diff;
    logic signed [MW-1:0]       rounded;
    logic signed [MW-1:0]       shifted;
    logic                       last_j;

    assign load_idx    = JW'(req.joint_index);
    assign idx_ok      = 32'(req.joint_index) < NUM_JOINTS;
    assign elapsed_sum = {1'b0, elapsed_reg} + (TW+1)'(tick_period_reg);
    assign elapsed_sat = elapsed_sum[TW] ? '1 : elapsed_sum[TW-1:0];
    assign goal_new    = (req.waypoint_time > elapsed_sat) ? req.waypoint_time : elapsed_sat;
    assign frac        = full_reg ? ONE : {1'b0, div_q};
    assign diff        = {target_rd_reg[PW-1], target_rd_reg} - {start_rd_reg[PW-1], start_rd_reg};
    assign rounded     = prod_reg + $signed(HALF);
    assign shifted     = rounded >>> FRACTION_BITS;
    assign last_j      = j_reg == JW'(NUM_JOINTS - 1);

    jti_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.prep),
        .num      (elapsed_reg - seg_start_reg),
        .span     (seg_goal_reg - seg_start_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = 1'b0;
        if (cmd.reject)
        begin
            result_next.out_joint_index = '0;
            result_next.out_position    = '0;
            result_next.last_joint      = 1'b0;
            result_next.status          = jti_pkg::STATUS_REJECT;
            result_valid_next           = 1'b1;
        end
        else if (cmd.emit)
        begin
            result_next.out_joint_index = 4'(j_reg);
            result_next.out_position    = start_rd_reg + shifted[PW-1:0];
            result_next.last_joint      = last_j;
            result_next.status          = jti_pkg::STATUS_POINT;
            result_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg  <= jti_pkg::TICK_PERIOD_RESET;
            mask_reg         <= '0;
            elapsed_reg      <= '0;
            seg_start_reg    <= '0;
            seg_goal_reg     <= '0;
            active_reg       <= 1'b0;
            full_reg         <= 1'b0;
            j_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                tick_period_reg <= cfg_wdata;
            if (cmd.load_target && idx_ok)
                mask_reg[load_idx] <= 1'b1;
            if (cmd.begin_seg)
            begin
                seg_goal_reg  <= goal_new;
                seg_start_reg <= elapsed_reg;
                active_reg    <= 1'b1;
                mask_reg      <= '0;
            end
            if (cmd.tick)
                elapsed_reg <= elapsed_sat;
            if (cmd.restart)
            begin
                elapsed_reg   <= '0;
                seg_start_reg <= '0;
                seg_goal_reg  <= '0;
                active_reg    <= 1'b0;
            end
            if (cmd.prep)
            begin
                full_reg <= elapsed_reg >= seg_goal_reg;
                j_reg    <= '0;
            end
            if (cmd.emit && !last_j)
                j_reg <= j_reg + JW'(1);
            if (cmd.finish && full_reg)
                active_reg <= 1'b0;
        end
    end

    // joint stores: loads from requests, targets copied to start on the final tick
    always_ff @(posedge clk)
    begin
        if (cmd.load_target && idx_ok)
            target_mem[load_idx] <= req.joint_position;
        if (cmd.load_start && idx_ok)
            start_mem[load_idx] <= req.joint_position;
        if (cmd.rd)
        begin
            start_rd_reg  <= start_mem[j_reg];
            target_rd_reg <= target_mem[j_reg];
            if (full_reg)
                start_mem[j_reg] <= target_mem[j_reg];
        end
        if (cmd.mul)
            prod_reg <= MW'(diff * $signed({1'b0, frac}));
        result_reg <= result_next;
    end

    assign stat.seg_active = active_reg;
    assign stat.mask_full  = &mask_reg;
    assign stat.div_done   = div_done;
    assign stat.last_joint = last_j;
    assign result          = result_reg;
    assign result_valid    = result_valid_reg;

endmodule

// ----- rtl/core/jti_ctrl.sv -----
// Controller: decodes requests and sequences divide and per-joint interpolation.
// Depends on jti_pkg.
module jti_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         opcode,
    input  jti_pkg::dp_stat_t  stat,
    output jti_pkg::ctrl_cmd_t cmd,
    output logic               busy
);
    jti_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= jti_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            jti_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        jti_pkg::OP_LOAD_TARGET: cmd.load_target = 1'b1;
                        jti_pkg::OP_LOAD_START:  cmd.load_start  = 1'b1;
                        jti_pkg::OP_BEGIN:
                        begin
                            if (!stat.seg_active)
                            begin
                                cmd.begin_seg = stat.mask_full;
                                cmd.reject    = !stat.mask_full;
                            end
                        end
                        jti_pkg::OP_TICK:
                        begin
                            if (stat.seg_active)
                            begin
                                cmd.tick   = 1'b1;
                                state_next = jti_pkg::ST_PREP;
                            end
                        end
                        jti_pkg::OP_RESTART: cmd.restart = 1'b1;
                        default: ;
                    endcase
                end
            end
            jti_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = jti_pkg::ST_DIV;
            end
            jti_pkg::ST_DIV:
            begin
                if (stat.div_done)
                    state_next = jti_pkg::ST_READ;
            end
            jti_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = jti_pkg::ST_MUL;
            end
            jti_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = jti_pkg::ST_EMIT;
            end
            jti_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.last_joint)
                begin
                    cmd.finish = 1'b1;
                    state_next = jti_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = jti_pkg::ST_READ;
                end
            end
            default: state_next = jti_pkg::ST_IDLE;
        endcase
    end

    assign busy = state_reg != jti_pkg::ST_IDLE;

endmodule

// ----- rtl/core/joint_trajectory_interpolator_top.sv -----
// Linear joint-space trajectory interpolator, top level.
// Depends on jti_pkg, jti_ctrl, jti_dp (and jti_div through jti_dp).
//
// A request is taken when start is high and busy is low. Load, begin and restart
// requests leave busy low; a rejected begin gives its one result (status 1) on the
// following cycle. A tick on an active segment raises busy while the block loads
// the divider, runs the serial divider at one fraction bit per cycle until its
// done flag rises, then takes each joint in turn through read, multiply and emit
// states and the shared multiplier. Results appear on result with result_valid
// high for exactly one cycle each and cannot be stalled; the receiver must take
// every strobe. tick_period may be written on any cycle the block is idle.
module joint_trajectory_interpolator_top #(
    parameter int NUM_JOINTS    = jti_pkg::NUM_JOINTS_DEF,
    parameter int FRACTION_BITS = jti_pkg::FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  jti_pkg::in_req_t           req,
    input  logic                       cfg_we,
    input  logic [jti_pkg::TICK_W-1:0] cfg_wdata,
    output jti_pkg::result_t           result,
    output logic                       result_valid
);
    jti_pkg::ctrl_cmd_t cmd;
    jti_pkg::dp_stat_t  stat;

    jti_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    jti_dp #(
        .NUM_JOINTS    (NUM_JOINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
